### sv/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants, types and helpers of the calorimeter trigger sum block.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int CHANNELS          = 4;
    localparam int ADC_W             = 14;
    localparam int IDX_W             = 5;
    localparam int CH_SUM_W          = 10;
    localparam int SUM_W             = 8;
    localparam int EVT_W             = 32;
    localparam int MAX_SAMPLES       = 32;
    localparam int DEFAULT_MAX_DELAY = 16;

    localparam int THR_W = 8;
    localparam int DLY_W = 4;
    localparam int SPW_W = 6;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);
    localparam logic [DLY_W-1:0] DLY_RESET = DLY_W'(6);
    localparam logic [SPW_W-1:0] SPW_RESET = SPW_W'(31);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SUB_DELAY = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = CFG_IDX_W'(2);

    // longest wave the sample counter can cover
    localparam int LEN_CAP = (MAX_SAMPLES < 32) ? MAX_SAMPLES : 32;

    typedef struct packed {
        logic             produce;
        logic [IDX_W-1:0] idx;
        logic             eog;
        logic             last_group;
        logic             masked;
        logic             dzero;
    } t_item_ctl;

    function automatic logic [SPW_W-1:0] wave_len(input logic [SPW_W-1:0] spw);
        logic [SPW_W-1:0] n;
        n = spw;
        if (n > SPW_W'(LEN_CAP)) n = SPW_W'(LEN_CAP);
        if (n < SPW_W'(2)) n = SPW_W'(2);
        return n;
    endfunction

endpackage

### sv/cts_in_if.sv
// ----------------------------------------------------------------------------
// cts_in_if
// Request channel carrying one time sample of a four-channel tower group.
// ----------------------------------------------------------------------------
interface cts_in_if;
    import cts_pkg::*;

    logic             valid;
    logic             ready;
    logic [ADC_W-1:0] adc_ch0;
    logic [ADC_W-1:0] adc_ch1;
    logic [ADC_W-1:0] adc_ch2;
    logic [ADC_W-1:0] adc_ch3;
    logic             masked;
    logic             last_group;

    modport source (
        output valid, adc_ch0, adc_ch1, adc_ch2, adc_ch3, masked, last_group,
        input  ready
    );
    modport sink (
        input  valid, adc_ch0, adc_ch1, adc_ch2, adc_ch3, masked, last_group,
        output ready
    );
endinterface

### sv/cts_out_if.sv
// ----------------------------------------------------------------------------
// cts_out_if
// Result channel carrying one trigger sum with peak and event summary.
// ----------------------------------------------------------------------------
interface cts_out_if;
    import cts_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] sample_index;
    logic [SUM_W-1:0] trig_sum;
    logic             fire;
    logic [SUM_W-1:0] peak_sum;
    logic [IDX_W-1:0] peak_index;
    logic             group_done;
    logic [EVT_W-1:0] event_bits;
    logic             event_pass;

    modport source (
        output valid, sample_index, trig_sum, fire, peak_sum, peak_index,
               group_done, event_bits, event_pass,
        input  ready
    );
    modport sink (
        input  valid, sample_index, trig_sum, fire, peak_sum, peak_index,
               group_done, event_bits, event_pass,
        output ready
    );
endinterface

### sv/cts_cfg_if.sv
// ----------------------------------------------------------------------------
// cts_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cts_cfg_if;
    import cts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/calo_trigger_sum_threshold.sv
// A sample's result passes stage one, stage two and the output register to reach o_out.
// Throughput: one sample per cycle unless o_out back-pressure stalls i_in.ready, set by
//   the single delay-line RAM that is read and written once per sample at acceptance.
// Reset (i_rst_n low, synchronous): clears sample position, peak, fire accumulation and
//   pipeline valids, and loads register defaults. The delay RAM is not cleared; a read
//   feeding a produced sum at nonzero delay hits an entry written earlier in the same group.
// ----------------------------------------------------------------------------
// calo_trigger_sum_threshold
// Four-channel pedestal-subtracted trigger sum with threshold, peak tracking
// and per-event fire accumulation around a delay-line RAM.
// ----------------------------------------------------------------------------
module calo_trigger_sum_threshold #(
    parameter int MAX_DELAY = cts_pkg::DEFAULT_MAX_DELAY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cts_cfg_if.sink    i_cfg,
    cts_in_if.sink     i_in,
    cts_out_if.source  o_out
);
    import cts_pkg::*;

    localparam int SLOT_W = $clog2(MAX_DELAY);
    localparam int LINE_W = CHANNELS * ADC_W;

    logic [THR_W-1:0] r_threshold;
    logic [DLY_W-1:0] r_sub_delay;
    logic [SPW_W-1:0] r_spw;

    logic              accept;
    logic [SLOT_W-1:0] wslot;
    logic [SLOT_W-1:0] rslot;
    t_item_ctl         s0_ctl;
    logic [LINE_W-1:0] s0_cur;
    logic [LINE_W-1:0] rdata;

    logic              r_s1_valid;
    t_item_ctl         r_s1_ctl;
    logic [LINE_W-1:0] r_s1_cur;

    logic              s2_valid;
    t_item_ctl         s2_ctl;
    logic [SUM_W-1:0]  s2_sum;
    logic              out_free;
    logic              s2_commit;
    logic              s2_free;
    logic              s1_move;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
            r_sub_delay <= DLY_RESET;
            r_spw       <= SPW_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_THRESHOLD: r_threshold <= i_cfg.data[THR_W-1:0];
                REG_SUB_DELAY: r_sub_delay <= i_cfg.data[DLY_W-1:0];
                REG_SAMPLES:   r_spw       <= i_cfg.data[SPW_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline flow: stage two may retire a no-result request without the output slot
    assign s2_commit  = s2_valid && (!s2_ctl.produce || out_free);
    assign s2_free    = !s2_valid || s2_commit;
    assign s1_move    = r_s1_valid && s2_free;
    assign i_in.ready = !r_s1_valid || s2_free;
    assign accept     = i_in.valid && i_in.ready;

    assign s0_cur = {i_in.adc_ch3, i_in.adc_ch2, i_in.adc_ch1, i_in.adc_ch0};

    cts_seq #(.MAX_DELAY(MAX_DELAY)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_masked     (i_in.masked),
        .i_last_group (i_in.last_group),
        .i_sub_delay  (r_sub_delay),
        .i_len        (wave_len(r_spw)),
        .o_ctl        (s0_ctl),
        .o_wslot      (wslot),
        .o_rslot      (rslot)
    );

    cts_ram #(.WIDTH(LINE_W), .DEPTH(MAX_DELAY)) u_line (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (wslot),
        .i_wdata (s0_cur),
        .i_re    (accept),
        .i_raddr (rslot),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ctl <= s0_ctl;
            r_s1_cur <= s0_cur;
        end
    end

    cts_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s1_move),
        .i_take  (s2_commit),
        .i_ctl   (r_s1_ctl),
        .i_cur   (r_s1_cur),
        .i_old   (rdata),
        .o_valid (s2_valid),
        .o_ctl   (s2_ctl),
        .o_sum   (s2_sum)
    );

    cts_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (s2_commit),
        .i_ctl       (s2_ctl),
        .i_sum       (s2_sum),
        .i_threshold (r_threshold),
        .o_out_free  (out_free),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted request did not reach stage one");
`endif

endmodule

### sv/cts_ram.sv
// ----------------------------------------------------------------------------
// cts_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cts_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/cts_seq.sv
// ----------------------------------------------------------------------------
// cts_seq
// Sample sequencer: position in the group, delay line slots, item control.
// ----------------------------------------------------------------------------
module cts_seq #(
    parameter  int MAX_DELAY = cts_pkg::DEFAULT_MAX_DELAY,
    localparam int SLOT_W    = $clog2(MAX_DELAY)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic                       i_masked,
    input  logic                       i_last_group,
    input  logic [cts_pkg::DLY_W-1:0]  i_sub_delay,
    input  logic [cts_pkg::SPW_W-1:0]  i_len,
    output cts_pkg::t_item_ctl         o_ctl,
    output logic [SLOT_W-1:0]          o_wslot,
    output logic [SLOT_W-1:0]          o_rslot
);
    import cts_pkg::*;

    localparam int DLY_MAX = (1 << DLY_W) - 1;
    localparam logic [DLY_W-1:0] DLY_CAP =
        DLY_W'((MAX_DELAY - 1 > DLY_MAX) ? DLY_MAX : MAX_DELAY - 1);
    localparam int SW = ((SLOT_W > DLY_W) ? SLOT_W : DLY_W) + 1;

    logic [IDX_W-1:0]  r_pos;
    logic [SLOT_W-1:0] r_wslot;
    logic [DLY_W-1:0]  dly;
    logic [SW-1:0]     rdiff;
    logic              eog;

    always_comb begin
        dly   = (i_sub_delay > DLY_CAP) ? DLY_CAP : i_sub_delay;
        eog   = (SPW_W'(r_pos) + SPW_W'(1)) >= i_len;
        rdiff = SW'(r_wslot) - SW'(dly);
        // wrap the read slot back into the ring
        o_rslot = rdiff[SW-1] ? SLOT_W'(rdiff + SW'(MAX_DELAY)) : SLOT_W'(rdiff);
        o_wslot = r_wslot;

        o_ctl.produce    = r_pos >= IDX_W'(dly);
        o_ctl.idx        = r_pos - IDX_W'(dly);
        o_ctl.eog        = eog;
        o_ctl.last_group = i_last_group;
        o_ctl.masked     = i_masked;
        o_ctl.dzero      = (dly == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_wslot <= '0;
        end else if (i_accept) begin
            if (eog) begin
                r_pos   <= '0;
                r_wslot <= '0;
            end else begin
                r_pos   <= r_pos + IDX_W'(1);
                r_wslot <= (r_wslot == SLOT_W'(MAX_DELAY - 1)) ? '0
                                                               : r_wslot + SLOT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_wslot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_wslot) < MAX_DELAY))
        else $error("delay line write slot out of range");
`endif

endmodule

### sv/cts_sum.sv
// ----------------------------------------------------------------------------
// cts_sum
// Pedestal subtraction and four-channel sum, registered into stage two.
// ----------------------------------------------------------------------------
module cts_sum (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_load,
    input  logic                                          i_take,
    input  cts_pkg::t_item_ctl                            i_ctl,
    input  logic [cts_pkg::CHANNELS*cts_pkg::ADC_W-1:0]   i_cur,
    input  logic [cts_pkg::CHANNELS*cts_pkg::ADC_W-1:0]   i_old,
    output logic                                          o_valid,
    output cts_pkg::t_item_ctl                            o_ctl,
    output logic [cts_pkg::SUM_W-1:0]                     o_sum
);
    import cts_pkg::*;

    logic               r_valid;
    t_item_ctl          r_ctl;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;

    always_comb begin
        logic [ADC_W:0]    diff;
        logic [CH_SUM_W-1:0] acc;
        acc = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            diff = {1'b0, i_cur[c*ADC_W +: ADC_W]} - {1'b0, i_old[c*ADC_W +: ADC_W]};
            // clamp negative differences, drop everything on zero delay
            if (!diff[ADC_W] && !i_ctl.dzero) begin
                acc = acc + CH_SUM_W'(diff[ADC_W-1:0] >> 4);
            end
        end
        n_sum = i_ctl.masked ? '0 : acc[CH_SUM_W-1:CH_SUM_W-SUM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ctl <= i_ctl;
            r_sum <= n_sum;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_sum   = r_sum;

endmodule

### sv/cts_accum.sv
// ----------------------------------------------------------------------------
// cts_accum
// Threshold, group peak tracking, event fire accumulation and output register.
// ----------------------------------------------------------------------------
module cts_accum (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_commit,
    input  cts_pkg::t_item_ctl           i_ctl,
    input  logic [cts_pkg::SUM_W-1:0]    i_sum,
    input  logic [cts_pkg::THR_W-1:0]    i_threshold,
    output logic                         o_out_free,
    cts_out_if.source                    o_out
);
    import cts_pkg::*;

    logic [SUM_W-1:0] r_peak;
    logic [IDX_W-1:0] r_peak_idx;
    logic [EVT_W-1:0] r_facc;
    logic             r_valid;

    logic [IDX_W-1:0] r_sample_index;
    logic [SUM_W-1:0] r_trig_sum;
    logic             r_fire;
    logic [SUM_W-1:0] r_peak_sum;
    logic [IDX_W-1:0] r_peak_index;
    logic             r_group_done;
    logic [EVT_W-1:0] r_event_bits;

    logic             fire;
    logic             upd;
    logic [SUM_W-1:0] n_peak;
    logic [IDX_W-1:0] n_peak_idx;
    logic [EVT_W-1:0] n_facc;
    logic             evt_end;

    always_comb begin
        fire       = i_ctl.produce && !i_ctl.masked && (i_sum >= i_threshold);
        upd        = i_ctl.produce && !i_ctl.masked && (r_peak < i_sum);
        n_peak     = upd ? i_sum : r_peak;
        n_peak_idx = upd ? i_ctl.idx : r_peak_idx;
        n_facc     = r_facc | (EVT_W'(fire) << i_ctl.idx);
        evt_end    = i_ctl.eog && i_ctl.last_group;
    end

    assign o_out_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak     <= '0;
            r_peak_idx <= '0;
            r_facc     <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_commit) begin
                // clear the peak at group end, the event mask at event end
                r_peak     <= i_ctl.eog ? '0 : n_peak;
                r_peak_idx <= i_ctl.eog ? '0 : n_peak_idx;
                r_facc     <= evt_end ? '0 : n_facc;
            end
            if (i_commit && i_ctl.produce) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit && i_ctl.produce) begin
            r_sample_index <= i_ctl.idx;
            r_trig_sum     <= i_sum;
            r_fire         <= fire;
            r_peak_sum     <= n_peak;
            r_peak_index   <= n_peak_idx;
            r_group_done   <= i_ctl.eog;
            r_event_bits   <= evt_end ? n_facc : '0;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.sample_index = r_sample_index;
    assign o_out.trig_sum     = r_trig_sum;
    assign o_out.fire         = r_fire;
    assign o_out.peak_sum     = r_peak_sum;
    assign o_out.peak_index   = r_peak_index;
    assign o_out.group_done   = r_group_done;
    assign o_out.event_bits   = r_event_bits;
    assign o_out.event_pass   = (r_event_bits != '0);

`ifndef NO_ASSERTIONS
    a_peak_covers_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_peak_sum >= r_trig_sum))
        else $error("reported peak below current sum");
    a_event_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_group_done) |-> (r_event_bits == '0))
        else $error("event bits shown before group end");
    a_fire_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && fire) |=> (r_facc[$past(i_ctl.idx)] || $past(evt_end)))
        else $error("fire bit lost from event accumulation");
`endif

endmodule
